@@ hdl/palette_color_cycler_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef PALETTE_COLOR_CYCLER_DEFINES_SVH
`define PALETTE_COLOR_CYCLER_DEFINES_SVH

// Implication checked in the same cycle, quiet during reset.
`define PCC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("palette_color_cycler check failed");

// Implication checked in the next cycle, quiet during reset.
`define PCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("palette_color_cycler check failed");

// Implication that also holds across reset.
`define PCC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("palette_color_cycler check failed");

`endif

@@ hdl/pcc_pkg.sv @@
package pcc_pkg;

  localparam int unsigned ENTRY_W    = 8;
  localparam int unsigned TIMER_W    = 8;
  localparam int unsigned SETUP_W    = 25;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PORT_COLOR_W = 32;
  localparam int unsigned MODE_W     = 2;

  localparam int unsigned SETUP_EN_BIT = 0;
  localparam int unsigned START_LSB    = 1;
  localparam int unsigned STOP_LSB     = 9;
  localparam int unsigned RELOAD_LSB   = 17;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CYC,
    S_LAP,
    S_DONE
  } pcc_state_t;

  typedef enum logic [1:0] {
    LAP_ROT,
    LAP_CAP,
    LAP_PUT,
    LAP_GET
  } pcc_lap_t;

endpackage

@@ hdl/pcc_cell.sv @@
module pcc_cell #(
  parameter int unsigned COLOR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic [COLOR_BITS-1:0] d,
  output logic [COLOR_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

@@ hdl/pcc_ctrl.sv @@
module pcc_ctrl
  import pcc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned NUM_CYCLES      = 8,
  parameter int unsigned COLOR_BITS      = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SETUP_W-1:0]      cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       mode,
  input  logic [ENTRY_W-1:0]      entry_index,
  input  logic [PORT_COLOR_W-1:0] color_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PORT_COLOR_W-1:0] color_out,
  output logic                    palette_changed,
  input  logic [COLOR_BITS-1:0]   head,
  input  logic [COLOR_BITS-1:0]   nxt,
  output logic                    shift,
  output logic [COLOR_BITS-1:0]   feed
);

  localparam int unsigned IW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned KW = (NUM_CYCLES > 1) ? $clog2(NUM_CYCLES) : 1;
  localparam logic [ENTRY_W:0]   LIMIT   = (ENTRY_W + 1)'(PALETTE_ENTRIES);
  localparam logic [IW-1:0]      LAST_IX = IW'(PALETTE_ENTRIES - 1);
  localparam logic [KW-1:0]      LAST_K  = KW'(NUM_CYCLES - 1);
  localparam logic [CFG_IDX_W:0] NUM_K   = (CFG_IDX_W + 1)'(NUM_CYCLES);

  pcc_state_t state, state_next;
  pcc_lap_t   lap;

  logic [SETUP_W-1:0]    setup  [NUM_CYCLES];
  logic [TIMER_W-1:0]    timers [NUM_CYCLES];
  logic [KW-1:0]         kidx;
  logic [IW-1:0]         hidx;
  logic [IW-1:0]         rf;
  logic [IW-1:0]         rl;
  logic [COLOR_BITS-1:0] hold;
  logic [MODE_W-1:0]     mode_r;
  logic                  changed;

  logic [SETUP_W-1:0] sel;
  logic               sel_en;
  logic [IW-1:0]      sel_start;
  logic [IW-1:0]      sel_stop;
  logic [TIMER_W-1:0] sel_reload;
  logic               sel_fire;
  logic               idx_ok;
  logic               lap_end;
  logic               last_k;
  logic               out_free;

  function automatic logic [IW-1:0] clamp_entry(input logic [ENTRY_W-1:0] e);
    logic [IW-1:0] r;
    if ({1'b0, e} >= LIMIT) begin
      r = LAST_IX;
    end else begin
      r = e[IW-1:0];
    end
    return r;
  endfunction

  assign sel        = setup[kidx];
  assign sel_en     = sel[SETUP_EN_BIT];
  assign sel_start  = clamp_entry(sel[START_LSB +: ENTRY_W]);
  assign sel_stop   = clamp_entry(sel[STOP_LSB +: ENTRY_W]);
  assign sel_reload = sel[RELOAD_LSB +: TIMER_W];
  assign sel_fire   = sel_en && (timers[kidx] == '0);
  assign idx_ok     = ({1'b0, entry_index} < LIMIT);
  assign lap_end    = (hidx == '0);
  assign last_k     = (kidx == LAST_K);
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (mode) inside
            MODE_TICK:             state_next = S_CYC;
            MODE_WRITE, MODE_READ: state_next = idx_ok ? S_LAP : S_DONE;
            default:               state_next = S_DONE;
          endcase
        end
      end
      S_CYC: begin
        if (sel_fire && (sel_start != sel_stop)) begin
          state_next = S_LAP;
        end else if (last_k) begin
          state_next = S_DONE;
        end
      end
      S_LAP: begin
        if (lap_end && (lap != LAP_CAP)) begin
          if (mode_r != MODE_TICK) begin
            state_next = S_DONE;
          end else if (last_k) begin
            state_next = S_DONE;
          end else begin
            state_next = S_CYC;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    shift    = (state == S_LAP);
    feed     = head;
    case (lap)
      LAP_ROT: begin
        if (hidx == rf) begin
          feed = hold;
        end else if ((hidx > rf) && (hidx <= rl)) begin
          feed = nxt;
        end
      end
      LAP_PUT: begin
        if (hidx == rf) begin
          feed = hold;
        end
      end
      default: feed = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CYCLES; i++) begin
        setup[i]  <= '0;
        timers[i] <= '0;
      end
    end else begin
      if (cfg_wr_en && ({1'b0, cfg_index} < NUM_K)) begin
        setup[cfg_index[KW-1:0]] <= cfg_wdata;
      end
      if ((state == S_CYC) && sel_en) begin
        if (sel_fire) begin
          timers[kidx] <= sel_reload;
        end else begin
          timers[kidx] <= timers[kidx] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kidx      <= '0;
      hidx      <= LAST_IX;
      lap       <= LAP_ROT;
      out_valid <= 1'b0;
      changed   <= 1'b0;
      mode_r    <= MODE_TICK;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= mode;
            changed <= 1'b0;
            kidx    <= '0;
            rf      <= entry_index[IW-1:0];
            if (mode == MODE_WRITE) begin
              hold <= color_in[COLOR_BITS-1:0];
              lap  <= LAP_PUT;
            end else begin
              hold <= '0;
              lap  <= LAP_GET;
            end
          end
        end
        S_CYC: begin
          if (sel_fire) begin
            changed <= 1'b1;
            rf      <= sel_start;
            rl      <= sel_stop;
            lap     <= (sel_start < sel_stop) ? LAP_ROT : LAP_CAP;
          end
          if (!(sel_fire && (sel_start != sel_stop)) && !last_k) begin
            kidx <= kidx + 1'b1;
          end
        end
        S_LAP: begin
          if (((lap == LAP_ROT) || (lap == LAP_CAP)) && (hidx == rl)) begin
            hold <= head;
          end
          if ((lap == LAP_GET) && (hidx == rf)) begin
            hold <= head;
          end
          if (lap_end) begin
            hidx <= LAST_IX;
            if (lap == LAP_CAP) begin
              lap <= LAP_PUT;
            end else if ((mode_r == MODE_TICK) && !last_k) begin
              kidx <= kidx + 1'b1;
            end
          end else begin
            hidx <= hidx - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            palette_changed <= changed && (mode_r == MODE_TICK);
            color_out       <= (mode_r == MODE_READ) ?
                               PORT_COLOR_W'(hold) : '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/palette_color_cycler.sv @@
// Channel  Handshake              Word
// in       in_valid / in_ready    mode, entry_index, color_in
// out      out_valid / out_ready  color_out, palette_changed
// cfg      cfg_wr_en              cfg_index, cfg_wdata
//
// A write or read circulates the palette once round the ring of cells past the head cell; an
// index beyond the palette skips that lap. A tick checks each color cycle in turn and takes
// one lap of the ring for each range rotated, two laps when start lies above stop. Reset
// clears the palette. A new word is taken while a finished result waits; a stalled result
// holds the block in its final state until out_ready.
module palette_color_cycler
  import pcc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned NUM_CYCLES      = 8,
  parameter int unsigned COLOR_BITS      = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SETUP_W-1:0]      cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       mode,
  input  logic [ENTRY_W-1:0]      entry_index,
  input  logic [PORT_COLOR_W-1:0] color_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PORT_COLOR_W-1:0] color_out,
  output logic                    palette_changed
);

  logic [COLOR_BITS-1:0] ring [PALETTE_ENTRIES];
  logic [COLOR_BITS-1:0] feed;
  logic                  shift;

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    if (i == PALETTE_ENTRIES - 1) begin : g_tail
      pcc_cell #(.COLOR_BITS(COLOR_BITS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (feed),
        .q     (ring[i])
      );
    end else begin : g_body
      pcc_cell #(.COLOR_BITS(COLOR_BITS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (ring[i+1]),
        .q     (ring[i])
      );
    end
  end

  pcc_ctrl #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .NUM_CYCLES      (NUM_CYCLES),
    .COLOR_BITS      (COLOR_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .entry_index     (entry_index),
    .color_in        (color_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .color_out       (color_out),
    .palette_changed (palette_changed),
    .head            (ring[0]),
    .nxt             (ring[1]),
    .shift           (shift),
    .feed            (feed)
  );

endmodule

@@ hdl/pcc_checker.sv @@
`include "palette_color_cycler_defines.svh"

module pcc_checker
  import pcc_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [PORT_COLOR_W-1:0] color_out,
  input logic                    palette_changed
);

  `PCC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(color_out) && $stable(palette_changed))
  `PCC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `PCC_ASSERT_SAME(a_result_after_work, clk, rst, $rose(out_valid), $past(!in_ready))
  `PCC_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst), !out_valid && in_ready)

endmodule

bind palette_color_cycler pcc_checker u_pcc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .color_out       (color_out),
  .palette_changed (palette_changed)
);
